>>> hdl/sfdkh_pkg.sv
package sfdkh_pkg;

  localparam int KEY_WORDS       = 4;
  localparam int DIGITS_PER_WORD = 12;
  localparam int CHARS           = KEY_WORDS * DIGITS_PER_WORD;
  localparam int LATENCY         = DIGITS_PER_WORD + CHARS + 1;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0000_0100_0193;
  localparam logic [63:0] RECIP_10  = 64'h0000_0000_CCCC_CCCD;
  localparam logic [3:0]  ASCII_HI  = 4'h3;

  typedef logic [KEY_WORDS-1:0][31:0] word_arr_t;
  typedef logic [CHARS-1:0][3:0]      digit_arr_t;

endpackage

>>> hdl/seeded_fnv1a_decimal_key_hash_top.sv
// Seeded FNV-1a hash (32-bit basis and prime, 64-bit product) of a four-word key printed as 48 decimal characters.
//
// Input: raise start with word0..word3 for one cycle; a transaction is taken
// at each rising edge with start high and busy low. busy is always low, so a
// new key may enter on every cycle.
// Output: done is high for exactly one cycle with hash_out valid. There is no
// back-pressure; the receiver must take each result in that cycle.
// Pipeline: from the accepting edge to the done cycle a key passes an input
// register, 12 stages of digit extraction by reciprocal multiply, then one
// FNV round per stage for the 48 characters. Throughput: one key per cycle.
// Configuration: hash_seed_wr writes hash_seed_data into the seed register;
// write it only while no key is in flight. The seed is sampled on entry.
// Reset: rst (synchronous, active high) clears every valid bit in the
// pipeline and sets the seed to zero; keys in flight are dropped.
module seeded_fnv1a_decimal_key_hash_top
  import sfdkh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] word0,
  input  logic [31:0] word1,
  input  logic [31:0] word2,
  input  logic [31:0] word3,
  input  logic        hash_seed_wr,
  input  logic [31:0] hash_seed_data,
  output logic        done,
  output logic [63:0] hash_out
);

  logic [31:0] hash_seed;
  word_arr_t   words;
  logic        split_vld;
  digit_arr_t  split_digits;
  logic [31:0] split_basis;

  logic        vld [0:CHARS];
  logic [63:0] h   [0:CHARS];
  digit_arr_t  dig [0:CHARS];

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (hash_seed_wr) begin
      hash_seed <= hash_seed_data;
    end
  end

  assign busy  = 1'b0;
  assign words = {word3, word2, word1, word0};

  sfdkh_digit_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (start && !busy),
    .in_words  (words),
    .in_basis  (FNV_BASIS ^ hash_seed),
    .out_vld   (split_vld),
    .out_digits(split_digits),
    .out_basis (split_basis)
  );

  assign vld[0] = split_vld;
  assign h[0]   = {32'b0, split_basis};
  assign dig[0] = split_digits;

  for (genvar c = 0; c < CHARS; c++) begin : g_round
    logic [63:0] mixed;
    assign mixed = h[c] ^ {56'b0, ASCII_HI, dig[c][c]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[c+1] <= 1'b0;
      end else begin
        vld[c+1] <= vld[c];
      end
      h[c+1]   <= mixed * FNV_PRIME;
      dig[c+1] <= dig[c];
    end
  end

  assign done     = vld[CHARS];
  assign hash_out = h[CHARS];

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY done) else $error("key lost in pipeline");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY)) else $error("result without key");
  a_digits: assert property (@(posedge clk) disable iff (rst)
    split_vld |-> (split_digits[0] <= 4'd9 && split_digits[CHARS-1] <= 4'd9))
    else $error("bad decimal digit");
  a_ready: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif

endmodule

>>> hdl/sfdkh_digit_split.sv
module sfdkh_digit_split
  import sfdkh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  word_arr_t  in_words,
  input  logic [31:0] in_basis,
  output logic       out_vld,
  output digit_arr_t out_digits,
  output logic [31:0] out_basis
);

  logic        vld [0:DIGITS_PER_WORD];
  word_arr_t   quo [0:DIGITS_PER_WORD];
  digit_arr_t  dig [0:DIGITS_PER_WORD];
  logic [31:0] bas [0:DIGITS_PER_WORD];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_vld;
    end
    quo[0] <= in_words;
    dig[0] <= '0;
    bas[0] <= in_basis;
  end

  for (genvar s = 0; s < DIGITS_PER_WORD; s++) begin : g_step
    word_arr_t  quo_next;
    digit_arr_t dig_next;

    always_comb begin
      logic [63:0] prod;
      logic [31:0] q;
      logic [31:0] r;
      dig_next = dig[s];
      for (int k = 0; k < KEY_WORDS; k++) begin
        prod = {32'b0, quo[s][k]} * RECIP_10;
        q    = {3'b0, prod[63:35]};
        r    = quo[s][k] - ((q << 3) + (q << 1));
        quo_next[k] = q;
        dig_next[k*DIGITS_PER_WORD + DIGITS_PER_WORD-1-s] = r[3:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      quo[s+1] <= quo_next;
      dig[s+1] <= dig_next;
      bas[s+1] <= bas[s];
    end
  end

  assign out_vld    = vld[DIGITS_PER_WORD];
  assign out_digits = dig[DIGITS_PER_WORD];
  assign out_basis  = bas[DIGITS_PER_WORD];

endmodule
